/* hdl/ifcr_pkg.sv */
// ----------------------------------------------------------------------------
// ifcr_pkg
// Shared constants, codes and types for the idle framed checksum receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package ifcr_pkg;

  // frame geometry and channel count
  localparam int FRAME_BYTES = 16;
  localparam int CHANNELS    = 2;
  // bytes that take part in the check: random, tick and sum words
  localparam int CHECK_BYTES = 12;

  localparam int OP_W   = 2;
  localparam int CH_W   = 1;
  localparam int BYTE_W = 8;
  localparam int ST_W   = 3;
  localparam int WORD_W = 32;
  // byte count saturates at FRAME_BYTES + 1
  localparam int CNT_W  = $clog2(FRAME_BYTES + 2);
  localparam int BIDX_W = $clog2(CHECK_BYTES);

  // opcodes
  localparam logic [OP_W-1:0] OP_BYTE  = 2'd0;
  localparam logic [OP_W-1:0] OP_IDLE  = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  // status codes
  localparam logic [ST_W-1:0] ST_BYTE  = 3'd0;
  localparam logic [ST_W-1:0] ST_GOOD  = 3'd1;
  localparam logic [ST_W-1:0] ST_LEN   = 3'd2;
  localparam logic [ST_W-1:0] ST_SUM   = 3'd3;
  localparam logic [ST_W-1:0] ST_QUERY = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [CH_W-1:0]   channel;
    logic [BYTE_W-1:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [WORD_W-1:0] latest_random;
    logic [WORD_W-1:0] latest_tick;
    logic [WORD_W-1:0] length_errors;
    logic [WORD_W-1:0] checksum_errors;
    logic [WORD_W-1:0] good_frames;
    logic [WORD_W-1:0] idle_events;
  } result_t;

endpackage

`default_nettype wire

/* hdl/ifcr_if.sv */
// ----------------------------------------------------------------------------
// ifcr_in_if / ifcr_out_if
// Valid/ready channels for received items and for result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface ifcr_in_if;
  logic                        valid;
  logic                        ready;
  logic [ifcr_pkg::OP_W-1:0]   opcode;
  logic [ifcr_pkg::CH_W-1:0]   channel;
  logic [ifcr_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output opcode, output channel, output rx_byte,
                  input ready);
  modport sink   (input valid, input opcode, input channel, input rx_byte,
                  output ready);
endinterface

interface ifcr_out_if;
  logic                        valid;
  logic                        ready;
  logic [ifcr_pkg::ST_W-1:0]   status;
  logic [ifcr_pkg::WORD_W-1:0] latest_random;
  logic [ifcr_pkg::WORD_W-1:0] latest_tick;
  logic [ifcr_pkg::WORD_W-1:0] length_errors;
  logic [ifcr_pkg::WORD_W-1:0] checksum_errors;
  logic [ifcr_pkg::WORD_W-1:0] good_frames;
  logic [ifcr_pkg::WORD_W-1:0] idle_events;

  modport source (output valid, output status, output latest_random,
                  output latest_tick, output length_errors,
                  output checksum_errors, output good_frames,
                  output idle_events, input ready);
  modport sink   (input valid, input status, input latest_random,
                  input latest_tick, input length_errors,
                  input checksum_errors, input good_frames,
                  input idle_events, output ready);
endinterface

`default_nettype wire

/* hdl/ifcr_chan_state.sv */
// ----------------------------------------------------------------------------
// ifcr_chan_state
// Per-channel burst store, length and sum check, and counters.
// ----------------------------------------------------------------------------
`default_nettype none

module ifcr_chan_state (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               fire,
  input  wire ifcr_pkg::in_item_t item,
  output ifcr_pkg::result_t       res
);

  localparam int CIDX_W = (ifcr_pkg::CHANNELS > 1) ? $clog2(ifcr_pkg::CHANNELS) : 1;

  // burst bytes: only written slots are ever checked, so no reset
  logic [ifcr_pkg::BYTE_W-1:0] frame_r [ifcr_pkg::CHANNELS][ifcr_pkg::CHECK_BYTES];

  logic [ifcr_pkg::CNT_W-1:0]  cnt_r    [ifcr_pkg::CHANNELS];
  logic [ifcr_pkg::CNT_W-1:0]  cnt_nxt  [ifcr_pkg::CHANNELS];
  logic [ifcr_pkg::WORD_W-1:0] rand_r   [ifcr_pkg::CHANNELS];
  logic [ifcr_pkg::WORD_W-1:0] rand_nxt [ifcr_pkg::CHANNELS];
  logic [ifcr_pkg::WORD_W-1:0] tick_r   [ifcr_pkg::CHANNELS];
  logic [ifcr_pkg::WORD_W-1:0] tick_nxt [ifcr_pkg::CHANNELS];
  logic [ifcr_pkg::WORD_W-1:0] len_r    [ifcr_pkg::CHANNELS];
  logic [ifcr_pkg::WORD_W-1:0] len_nxt  [ifcr_pkg::CHANNELS];
  logic [ifcr_pkg::WORD_W-1:0] sum_r    [ifcr_pkg::CHANNELS];
  logic [ifcr_pkg::WORD_W-1:0] sum_nxt  [ifcr_pkg::CHANNELS];
  logic [ifcr_pkg::WORD_W-1:0] good_r   [ifcr_pkg::CHANNELS];
  logic [ifcr_pkg::WORD_W-1:0] good_nxt [ifcr_pkg::CHANNELS];
  logic [ifcr_pkg::WORD_W-1:0] idle_r   [ifcr_pkg::CHANNELS];
  logic [ifcr_pkg::WORD_W-1:0] idle_nxt [ifcr_pkg::CHANNELS];

  logic [CIDX_W-1:0]           ch;
  logic [ifcr_pkg::WORD_W-1:0] w_rand;
  logic [ifcr_pkg::WORD_W-1:0] w_tick;
  logic [ifcr_pkg::WORD_W-1:0] w_sum;
  logic                        sum_ok;
  logic                        byte_wr;
  logic [ifcr_pkg::ST_W-1:0]   status;

  // out-of-range channels fold onto the last one
  always_comb begin
    if (int'(item.channel) >= ifcr_pkg::CHANNELS) begin
      ch = CIDX_W'(ifcr_pkg::CHANNELS - 1);
    end else begin
      ch = CIDX_W'(item.channel);
    end
  end

  // little-endian words of the stored burst
  assign w_rand = {frame_r[ch][3], frame_r[ch][2], frame_r[ch][1], frame_r[ch][0]};
  assign w_tick = {frame_r[ch][7], frame_r[ch][6], frame_r[ch][5], frame_r[ch][4]};
  assign w_sum  = {frame_r[ch][11], frame_r[ch][10], frame_r[ch][9], frame_r[ch][8]};
  assign sum_ok = (w_sum == w_rand + w_tick);

  // next state of the addressed channel
  always_comb begin
    cnt_nxt  = cnt_r;
    rand_nxt = rand_r;
    tick_nxt = tick_r;
    len_nxt  = len_r;
    sum_nxt  = sum_r;
    good_nxt = good_r;
    idle_nxt = idle_r;
    byte_wr  = 1'b0;
    status   = ifcr_pkg::ST_QUERY;
    case (item.opcode)
      ifcr_pkg::OP_BYTE: begin
        status = ifcr_pkg::ST_BYTE;
        if (cnt_r[ch] < ifcr_pkg::CNT_W'(ifcr_pkg::CHECK_BYTES)) begin
          byte_wr = 1'b1;
        end
        if (cnt_r[ch] <= ifcr_pkg::CNT_W'(ifcr_pkg::FRAME_BYTES)) begin
          cnt_nxt[ch] = cnt_r[ch] + ifcr_pkg::CNT_W'(1);
        end
      end
      ifcr_pkg::OP_IDLE: begin
        idle_nxt[ch] = idle_r[ch] + 32'd1;
        cnt_nxt[ch]  = '0;
        if (cnt_r[ch] != ifcr_pkg::CNT_W'(ifcr_pkg::FRAME_BYTES)) begin
          len_nxt[ch] = len_r[ch] + 32'd1;
          status      = ifcr_pkg::ST_LEN;
        end else if (sum_ok) begin
          rand_nxt[ch] = w_rand;
          tick_nxt[ch] = w_tick;
          good_nxt[ch] = good_r[ch] + 32'd1;
          status       = ifcr_pkg::ST_GOOD;
        end else begin
          sum_nxt[ch] = sum_r[ch] + 32'd1;
          status      = ifcr_pkg::ST_SUM;
        end
      end
      default: begin
        status = ifcr_pkg::ST_QUERY;
      end
    endcase
  end

  // result reflects the channel after this item
  always_comb begin
    res.status          = status;
    res.latest_random   = rand_nxt[ch];
    res.latest_tick     = tick_nxt[ch];
    res.length_errors   = len_nxt[ch];
    res.checksum_errors = sum_nxt[ch];
    res.good_frames     = good_nxt[ch];
    res.idle_events     = idle_nxt[ch];
  end

  // channel counters and latched words
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ifcr_pkg::CHANNELS; i++) begin
        cnt_r[i]  <= '0;
        rand_r[i] <= '0;
        tick_r[i] <= '0;
        len_r[i]  <= '0;
        sum_r[i]  <= '0;
        good_r[i] <= '0;
        idle_r[i] <= '0;
      end
    end else if (fire) begin
      cnt_r  <= cnt_nxt;
      rand_r <= rand_nxt;
      tick_r <= tick_nxt;
      len_r  <= len_nxt;
      sum_r  <= sum_nxt;
      good_r <= good_nxt;
      idle_r <= idle_nxt;
    end
  end

  // burst byte store
  always_ff @(posedge clk) begin
    if (fire && byte_wr) begin
      frame_r[ch][cnt_r[ch][ifcr_pkg::BIDX_W-1:0]] <= item.rx_byte;
    end
  end

  // byte count never passes its saturation point
  a_cnt_sat: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r[0] <= ifcr_pkg::CNT_W'(ifcr_pkg::FRAME_BYTES + 1))
    else $error("byte count past saturation");

  // an idle item bumps its channel's idle count and clears the burst
  a_idle: assert property (@(posedge clk) disable iff (!rst_n)
    fire && item.opcode == ifcr_pkg::OP_IDLE |=>
      idle_r[$past(ch)] == $past(idle_r[ch]) + 32'd1 && cnt_r[$past(ch)] == '0)
    else $error("idle item did not close the burst");

  // nothing moves without an item
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(good_r[0]) && $stable(len_r[0]) && $stable(cnt_r[0]))
    else $error("channel state changed without an item");

  // a good frame is the only thing that moves the latched words
  a_latch: assert property (@(posedge clk) disable iff (!rst_n)
    fire && status != ifcr_pkg::ST_GOOD |=> $stable(rand_r[0]) && $stable(tick_r[0]))
    else $error("latched words changed without a good frame");

endmodule

`default_nettype wire

/* hdl/idle_framed_checksum_receiver.sv */
// ----------------------------------------------------------------------------
// idle_framed_checksum_receiver
// Two-channel burst receiver that checks 16-byte idle-framed checksum frames.
// ----------------------------------------------------------------------------
//  channel   dir   handshake         payload
//  in_if     in    valid / ready     opcode, channel, rx_byte
//  out_if    out   valid / ready     status, latest words, four counters
//
//  one item per cycle sustained while out_if.ready is high; an item goes from
//  the input register through the channel state update (one 32-bit add and
//  compare) into the result register, with no register between the two
//  reset clears all counters, latched words and byte counts at once
//  a stalled result holds in the output register; one more item is held in
//  the input register before in_if.ready drops
// ----------------------------------------------------------------------------
`default_nettype none

module idle_framed_checksum_receiver (
  input  wire logic    clk,
  input  wire logic    rst_n,
  ifcr_in_if.sink      in_if,
  ifcr_out_if.source   out_if
);

  logic               s1_valid_r;
  ifcr_pkg::in_item_t s1_item_r;
  logic               out_valid_r;
  ifcr_pkg::result_t  out_res_r;
  ifcr_pkg::result_t  res;
  logic               advance;
  logic               fire;
  logic               in_ready;

  // pipeline flow control
  assign advance  = !out_valid_r || out_if.ready;
  assign fire     = s1_valid_r && advance;
  assign in_ready = !s1_valid_r || advance;

  assign in_if.ready = in_ready;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_if.valid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // input and result payload registers
  always_ff @(posedge clk) begin
    if (in_if.valid && in_ready) begin
      s1_item_r.opcode  <= in_if.opcode;
      s1_item_r.channel <= in_if.channel;
      s1_item_r.rx_byte <= in_if.rx_byte;
    end
    if (fire) begin
      out_res_r <= res;
    end
  end

  ifcr_chan_state u_chan_state (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (s1_item_r),
    .res   (res)
  );

  // result channel
  assign out_if.valid           = out_valid_r;
  assign out_if.status          = out_res_r.status;
  assign out_if.latest_random   = out_res_r.latest_random;
  assign out_if.latest_tick     = out_res_r.latest_tick;
  assign out_if.length_errors   = out_res_r.length_errors;
  assign out_if.checksum_errors = out_res_r.checksum_errors;
  assign out_if.good_frames     = out_res_r.good_frames;
  assign out_if.idle_events     = out_res_r.idle_events;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_if.ready |=> out_valid_r && $stable(out_res_r))
    else $error("stalled result changed");

  // input register is never overwritten while its item waits
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !advance |=> s1_valid_r && $stable(s1_item_r))
    else $error("waiting item lost");

  // every item leaving the input register lands in the result register
  a_move: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r)
    else $error("item dropped between stages");

endmodule

`default_nettype wire

/* tb/idle_framed_checksum_receiver_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idle_framed_checksum_receiver_tb
// Self-checking bench for the two-channel idle framed checksum receiver.
// A queue of byte, idle and query items feeds a valid/ready driver with random
// gaps. A monitor predicts each result from a private copy of the per-channel
// burst and counter state, and compares every result field by field.
// ----------------------------------------------------------------------------

module idle_framed_checksum_receiver_tb;

  // unused opcode, must behave as a query
  localparam logic [ifcr_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_PRINTED = 100;

  logic clk;
  logic rst_n;

  ifcr_in_if  in_ch ();
  ifcr_out_if out_ch ();

  idle_framed_checksum_receiver i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  // clock
  always #5 clk = ~clk;

  // stimulus and scoreboard state
  ifcr_pkg::in_item_t pending_items [$];
  ifcr_pkg::in_item_t lane_items [ifcr_pkg::CHANNELS][$];
  ifcr_pkg::result_t  awaited_reports [$];
  int          items_queued;
  int          items_accepted;
  int          results_seen;
  int          mismatch_count;
  int          cycle_count;
  bit          idling_on;
  bit          in_item_taken;
  int          send_gap;
  int          stall_left;

  // predicted per-channel receiver state
  logic [7:0] burst_bytes [ifcr_pkg::CHANNELS][ifcr_pkg::FRAME_BYTES];
  int         burst_len   [ifcr_pkg::CHANNELS];
  logic [ifcr_pkg::WORD_W-1:0] rnd_word    [ifcr_pkg::CHANNELS];
  logic [ifcr_pkg::WORD_W-1:0] tick_word   [ifcr_pkg::CHANNELS];
  logic [ifcr_pkg::WORD_W-1:0] len_err_cnt [ifcr_pkg::CHANNELS];
  logic [ifcr_pkg::WORD_W-1:0] sum_err_cnt [ifcr_pkg::CHANNELS];
  logic [ifcr_pkg::WORD_W-1:0] good_cnt    [ifcr_pkg::CHANNELS];
  logic [ifcr_pkg::WORD_W-1:0] idle_cnt    [ifcr_pkg::CHANNELS];

  task automatic report_mismatch(string what, logic [ifcr_pkg::WORD_W-1:0] got,
                                 logic [ifcr_pkg::WORD_W-1:0] want);
    if (mismatch_count < MAX_PRINTED)
      $display("mismatch on %s at result %0d: got %h, expected %h",
               what, results_seen, got, want);
    mismatch_count++;
  endtask

  // little-endian word w of the stored burst
  function automatic logic [ifcr_pkg::WORD_W-1:0] le_word(int ch, int w);
    return {burst_bytes[ch][4*w+3], burst_bytes[ch][4*w+2],
            burst_bytes[ch][4*w+1], burst_bytes[ch][4*w]};
  endfunction

  // apply one accepted item to the predicted state, return its status report
  function automatic ifcr_pkg::result_t apply_rx_item(ifcr_pkg::in_item_t it);
    int                          ch;
    logic [ifcr_pkg::WORD_W-1:0] r;
    logic [ifcr_pkg::WORD_W-1:0] t;
    logic [ifcr_pkg::WORD_W-1:0] s;
    ifcr_pkg::result_t           res;
    ch = int'(it.channel);
    if (ch >= ifcr_pkg::CHANNELS) ch = ifcr_pkg::CHANNELS - 1;
    case (it.opcode)
      ifcr_pkg::OP_BYTE: begin
        if (burst_len[ch] < ifcr_pkg::FRAME_BYTES)
          burst_bytes[ch][burst_len[ch]] = it.rx_byte;
        // count stops one past a full frame
        if (burst_len[ch] <= ifcr_pkg::FRAME_BYTES) burst_len[ch]++;
        res.status = ifcr_pkg::ST_BYTE;
      end
      ifcr_pkg::OP_IDLE: begin
        idle_cnt[ch]++;
        if (burst_len[ch] != ifcr_pkg::FRAME_BYTES) begin
          len_err_cnt[ch]++;
          res.status = ifcr_pkg::ST_LEN;
        end else begin
          r = le_word(ch, 0);
          t = le_word(ch, 1);
          s = le_word(ch, 2);
          if (s == r + t) begin
            rnd_word[ch]  = r;
            tick_word[ch] = t;
            good_cnt[ch]++;
            res.status = ifcr_pkg::ST_GOOD;
          end else begin
            sum_err_cnt[ch]++;
            res.status = ifcr_pkg::ST_SUM;
          end
        end
        burst_len[ch] = 0;
      end
      default: res.status = ifcr_pkg::ST_QUERY;
    endcase
    res.latest_random   = rnd_word[ch];
    res.latest_tick     = tick_word[ch];
    res.length_errors   = len_err_cnt[ch];
    res.checksum_errors = sum_err_cnt[ch];
    res.good_frames     = good_cnt[ch];
    res.idle_events     = idle_cnt[ch];
    return res;
  endfunction

  task automatic push_item(logic [ifcr_pkg::OP_W-1:0] op, int ch, logic [7:0] b);
    ifcr_pkg::in_item_t it;
    it.opcode  = op;
    it.channel = ch[ifcr_pkg::CH_W-1:0];
    it.rx_byte = b;
    pending_items.push_back(it);
    items_queued++;
  endtask

  // burst of len bytes on one lane, closed by an idle; bytes past the frame are random
  task automatic append_burst(int ch, int len, logic [127:0] frame);
    ifcr_pkg::in_item_t it;
    it.channel = ch[ifcr_pkg::CH_W-1:0];
    it.opcode  = ifcr_pkg::OP_BYTE;
    for (int i = 0; i < len; i++) begin
      it.rx_byte = (i < ifcr_pkg::FRAME_BYTES) ? frame[8*i +: 8] : 8'($urandom);
      lane_items[ch].push_back(it);
    end
    it.opcode  = ifcr_pkg::OP_IDLE;
    it.rx_byte = 8'($urandom);
    lane_items[ch].push_back(it);
  endtask

  function automatic logic [ifcr_pkg::WORD_W-1:0] pick_word();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // mostly good frames, some with a broken sum, wrong length or overflow
  task automatic append_random_burst(int ch);
    int                          roll;
    int                          len;
    logic [ifcr_pkg::WORD_W-1:0] r;
    logic [ifcr_pkg::WORD_W-1:0] t;
    logic [ifcr_pkg::WORD_W-1:0] s;
    logic [ifcr_pkg::WORD_W-1:0] d;
    roll = $urandom_range(0, 99);
    r    = pick_word();
    t    = pick_word();
    s    = r + t;
    d    = $urandom;
    len  = ifcr_pkg::FRAME_BYTES;
    if (roll >= 90)
      len = ($urandom_range(0, 9) == 0)
            ? $urandom_range(ifcr_pkg::FRAME_BYTES + 1, 50)
            : $urandom_range(ifcr_pkg::FRAME_BYTES + 1, ifcr_pkg::FRAME_BYTES + 4);
    else if (roll >= 80)
      len = $urandom_range(0, ifcr_pkg::FRAME_BYTES - 1);
    else if (roll >= 72)
      s = $urandom;
    else if (roll >= 55)
      s = s ^ (32'h1 << $urandom_range(0, 31));
    append_burst(ch, len, {d, s, t, r});
  endtask

  // interleave both lanes into the send queue, optionally with stray query and unused-opcode items as noise
  task automatic merge_lanes(bit with_noise);
    int lane;
    while (lane_items[0].size() != 0 || lane_items[1].size() != 0) begin
      if (with_noise && $urandom_range(0, 11) == 0)
        push_item(($urandom_range(0, 1) != 0) ? ifcr_pkg::OP_QUERY : OP_UNUSED,
                  $urandom_range(0, 1), 8'($urandom));
      if (lane_items[0].size() == 0)      lane = 1;
      else if (lane_items[1].size() == 0) lane = 0;
      else                                lane = $urandom_range(0, 1);
      pending_items.push_back(lane_items[lane].pop_front());
      items_queued++;
    end
  endtask

  task automatic add_random_until(int target);
    while (items_queued < target) begin
      if ($urandom_range(0, 4) != 0) append_random_burst(0);
      if ($urandom_range(0, 4) != 0) append_random_burst(1);
      merge_lanes(1'b1);
    end
  endtask

  // hold off until every queued item is taken and every report has come back
  task automatic wait_all_done();
    while (items_accepted != items_queued || awaited_reports.size() != 0)
      @(negedge clk);
  endtask

  // item driver
  always @(negedge clk) begin
    logic               next_valid;
    ifcr_pkg::in_item_t next_item;
    next_valid = in_ch.valid;
    next_item  = {in_ch.opcode, in_ch.channel, in_ch.rx_byte};
    if (!rst_n) begin
      next_valid = 1'b0;
    end else if (!in_ch.valid || in_item_taken) begin
      next_valid = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        send_gap = $urandom_range(1, 7) - 1;
      end else if (pending_items.size() != 0) begin
        next_item  = pending_items.pop_front();
        next_valid = 1'b1;
      end
    end
    in_ch.valid   <= next_valid;
    in_ch.opcode  <= next_item.opcode;
    in_ch.channel <= next_item.channel;
    in_ch.rx_byte <= next_item.rx_byte;
  end

  // result sink with stall bursts
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if (idling_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 7) - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // monitor: check results, then predict from the item taken at this edge
  always @(posedge clk) begin
    ifcr_pkg::result_t want;
    in_item_taken = rst_n && in_ch.valid && in_ch.ready;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (awaited_reports.size() == 0) begin
        report_mismatch("unexpected result status", 32'(out_ch.status), '0);
      end else begin
        want = awaited_reports.pop_front();
        if (out_ch.status !== want.status)
          report_mismatch("status", 32'(out_ch.status), 32'(want.status));
        if (out_ch.latest_random !== want.latest_random)
          report_mismatch("latest_random", out_ch.latest_random, want.latest_random);
        if (out_ch.latest_tick !== want.latest_tick)
          report_mismatch("latest_tick", out_ch.latest_tick, want.latest_tick);
        if (out_ch.length_errors !== want.length_errors)
          report_mismatch("length_errors", out_ch.length_errors, want.length_errors);
        if (out_ch.checksum_errors !== want.checksum_errors)
          report_mismatch("checksum_errors", out_ch.checksum_errors,
                          want.checksum_errors);
        if (out_ch.good_frames !== want.good_frames)
          report_mismatch("good_frames", out_ch.good_frames, want.good_frames);
        if (out_ch.idle_events !== want.idle_events)
          report_mismatch("idle_events", out_ch.idle_events, want.idle_events);
      end
      results_seen++;
    end
    if (in_item_taken) begin
      awaited_reports.push_back(apply_rx_item({in_ch.opcode, in_ch.channel,
                                               in_ch.rx_byte}));
      items_accepted++;
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILURE");
      $finish;
    end
  end

  // stimulus sequence
  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.opcode   = ifcr_pkg::OP_QUERY;
    in_ch.channel  = '0;
    in_ch.rx_byte  = '0;
    out_ch.ready   = 1'b0;
    idling_on      = 1'b1;
    in_item_taken  = 1'b0;
    send_gap       = 0;
    stall_left     = 0;
    items_queued   = 0;
    items_accepted = 0;
    results_seen   = 0;
    mismatch_count = 0;
    cycle_count    = 0;
    for (int c = 0; c < ifcr_pkg::CHANNELS; c++) begin
      for (int i = 0; i < ifcr_pkg::FRAME_BYTES; i++) burst_bytes[c][i] = '0;
      burst_len[c]   = 0;
      rnd_word[c]    = '0;
      tick_word[c]   = '0;
      len_err_cnt[c] = '0;
      sum_err_cnt[c] = '0;
      good_cnt[c]    = '0;
      idle_cnt[c]    = '0;
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: queries on fresh state, unused opcode, empty burst,
    // good frame whose sum wraps past 2^32, then readback
    push_item(ifcr_pkg::OP_QUERY, 0, 8'h00);
    push_item(OP_UNUSED, 1, 8'hFF);
    push_item(ifcr_pkg::OP_IDLE, 0, 8'h00);
    append_burst(1, ifcr_pkg::FRAME_BYTES, {32'h00FF_7F80, 32'h0000_0000,
                                            32'h0000_0001, 32'hFFFF_FFFF});
    merge_lanes(1'b0);
    push_item(ifcr_pkg::OP_QUERY, 1, 8'h5A);
    push_item(ifcr_pkg::OP_QUERY, 0, 8'hA5);
    wait_all_done();

    // random bursts with idling on both sides
    add_random_until(700);
    wait_all_done();

    // alternate stretches with and without idling
    for (int k = 0; k < 4; k++) begin
      idling_on = (k % 2 == 0);
      add_random_until(items_queued + 150);
      wait_all_done();
    end

    // final stretch at full rate
    idling_on = 1'b0;
    add_random_until(items_queued + 200);
    wait_all_done();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && awaited_reports.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* idle_framed_checksum_receiver.f */
hdl/ifcr_pkg.sv
hdl/ifcr_if.sv
hdl/ifcr_chan_state.sv
hdl/idle_framed_checksum_receiver.sv
tb/idle_framed_checksum_receiver_tb.sv
